[hdl/dac_pkg.sv]
// Shared types and constants for the distance antimagic labeling checker.
// No dependencies; imported by the lane, merge and top-level modules.
package dac_pkg;

  localparam int NUM_LABELS = 8;   // label ports and weight ports
  localparam int LABEL_W    = 4;   // width of each label port
  localparam int WEIGHT_W   = 7;   // width of each weight port
  localparam int ROW_W      = 8;   // columns per adjacency row
  localparam int ADJ_W      = 64;  // adjacency register width
  localparam int CNT_W      = 4;   // vertex count register width
  localparam int PADDR_W    = 4;   // byte addresses 0 and 8
  localparam int PDATA_W    = 64;

  // Register select: bit 3 of the byte address.
  typedef enum logic {
    REG_ADJ = 1'b0,
    REG_CNT = 1'b1
  } reg_sel_t;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [LABEL_W-1:0]  label_t;

  typedef struct packed {
    logic is_antimagic;
    logic has_twins;
  } flags_t;

endpackage

[hdl/dac_lane.sv]
// One vertex lane: sums the labels of the neighbours selected by its row.
// Depends on dac_pkg.
module dac_lane import dac_pkg::*; #(
  parameter int MAX_VERTICES = 8,
  parameter int LABEL_BITS   = 4
) (
  input  label_t  labels [NUM_LABELS],
  input  row_t    row,
  output weight_t weight
);

  localparam int LW    = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int SUM_W = $clog2(MAX_VERTICES * ((1 << LW) - 1) + 1);
  localparam label_t LMASK = LABEL_W'((1 << LW) - 1);

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_LABELS; j++) begin
      if (row[j]) begin
        sum = sum + SUM_W'(labels[j] & LMASK);
      end
    end
  end

  // Sum never exceeds the port range with 4-bit labels.
  assign weight = WEIGHT_W'(sum);

endmodule

[hdl/dac_merge.sv]
// Merge stage: pairwise compares the lane weights and adjacency rows.
// Depends on dac_pkg.
module dac_merge import dac_pkg::*; (
  input  weight_t                 weights [NUM_LABELS],
  input  row_t                    rows    [NUM_LABELS],
  input  logic [NUM_LABELS-1:0]   active,
  output flags_t                  flags
);

  logic distinct;
  logic twins;

  always_comb begin
    distinct = 1'b1;
    twins    = 1'b0;
    for (int i = 0; i < NUM_LABELS; i++) begin
      for (int j = i + 1; j < NUM_LABELS; j++) begin
        if (active[i] && active[j]) begin
          if (weights[i] == weights[j]) begin
            distinct = 1'b0;
          end
          if (rows[i] == rows[j]) begin
            twins = 1'b1;
          end
        end
      end
    end
    flags.is_antimagic = distinct;
    flags.has_twins    = twins;
  end

endmodule

[hdl/distance_antimagic_check_top.sv]
// Top level of the distance antimagic labeling checker: register port,
// lane array, merge stage and the two-stage request pipeline.
// Depends on dac_pkg, dac_lane and dac_merge.
//
// Usage:
//   A request carries eight vertex labels on label_0..label_7 and is taken
//   when in_valid and in_ready are both high. Each request yields exactly
//   one result on weight_0..weight_7, is_antimagic and has_twins, offered
//   with out_valid and taken when out_ready is high.
//   The lanes register all eight weights at the accepting edge, then, once the
//   result stage is free, the merge stage registers the flags and raises out_valid.
//   One request per cycle is sustained while out_ready stays high; the rate is
//   set by the lane adder trees and the 28-pair compare in the merge stage,
//   each with a register of its own.
//   When out_ready is low the result holds, the stage behind it fills, and
//   in_ready drops only when both stages are full.
//   The graph lives in adjacency_bits (byte address 0) and vertex_count
//   (byte address 8) on the APB-style port; write them only while no
//   request is in flight. Reset empties the pipeline, clears adjacency_bits
//   and sets vertex_count to 8.
module distance_antimagic_check_top import dac_pkg::*; #(
  parameter int MAX_VERTICES = 8,
  parameter int LABEL_BITS   = 4
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  label_t             label_0,
  input  label_t             label_1,
  input  label_t             label_2,
  input  label_t             label_3,
  input  label_t             label_4,
  input  label_t             label_5,
  input  label_t             label_6,
  input  label_t             label_7,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_antimagic,
  output logic               has_twins,
  output weight_t            weight_0,
  output weight_t            weight_1,
  output weight_t            weight_2,
  output weight_t            weight_3,
  output weight_t            weight_4,
  output weight_t            weight_5,
  output weight_t            weight_6,
  output weight_t            weight_7
);

  // ---------------- configuration registers ----------------
  logic [ADJ_W-1:0] adjacency_bits;
  logic [CNT_W-1:0] vertex_count;
  reg_sel_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      adjacency_bits <= '0;
      vertex_count   <= CNT_W'(8);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_ADJ: adjacency_bits <= pwdata[ADJ_W-1:0];
        REG_CNT: vertex_count   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ADJ: prdata = PDATA_W'(adjacency_bits);
      REG_CNT: prdata = PDATA_W'(vertex_count);
      default: prdata = '0;
    endcase
  end

  // ---------------- vertices in use ----------------
  logic [CNT_W-1:0]      count_eff;
  logic [NUM_LABELS-1:0] active;
  row_t                  rows [NUM_LABELS];

  assign count_eff = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                           : vertex_count;

  always_comb begin
    for (int k = 0; k < NUM_LABELS; k++) begin
      active[k] = (CNT_W'(k) < count_eff);
    end
    // only columns in use count; rows of unused vertices read zero
    for (int k = 0; k < NUM_LABELS; k++) begin
      rows[k] = active[k] ? (adjacency_bits[k*ROW_W +: ROW_W] & active) : '0;
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid;
  logic s1_adv;
  logic s2_adv;

  assign s2_adv   = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= in_valid;
      end
      if (s2_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // ---------------- lanes ----------------
  label_t  labels     [NUM_LABELS];
  weight_t lane_weight[NUM_LABELS];
  weight_t s1_weight  [NUM_LABELS];
  logic [NUM_LABELS-1:0] s1_active;

  assign labels[0] = label_0;
  assign labels[1] = label_1;
  assign labels[2] = label_2;
  assign labels[3] = label_3;
  assign labels[4] = label_4;
  assign labels[5] = label_5;
  assign labels[6] = label_6;
  assign labels[7] = label_7;

  for (genvar g = 0; g < NUM_LABELS; g++) begin : g_lane
    dac_lane #(
      .MAX_VERTICES (MAX_VERTICES),
      .LABEL_BITS   (LABEL_BITS)
    ) u_lane (
      .labels (labels),
      .row    (rows[g]),
      .weight (lane_weight[g])
    );
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_weight <= lane_weight;
      s1_active <= active;
    end
  end

  // ---------------- merge ----------------
  flags_t merge_flags;

  dac_merge u_merge (
    .weights (s1_weight),
    .rows    (rows),
    .active  (s1_active),
    .flags   (merge_flags)
  );

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      is_antimagic <= merge_flags.is_antimagic;
      has_twins    <= merge_flags.has_twins;
      weight_0     <= s1_weight[0];
      weight_1     <= s1_weight[1];
      weight_2     <= s1_weight[2];
      weight_3     <= s1_weight[3];
      weight_4     <= s1_weight[4];
      weight_5     <= s1_weight[5];
      weight_6     <= s1_weight[6];
      weight_7     <= s1_weight[7];
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted request missing from lane stage");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result stage empty");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_adv) |=> (s1_valid && $stable(s1_active)))
    else $error("lane stage lost or changed a request under stall");
`endif

endmodule

[tb/distance_antimagic_check_top_test.sv]
// Self-checking testbench for distance_antimagic_check_top: drives labelings
// with random gaps, programs graphs over the register port, checks each result.
// Depends on dac_pkg and the RTL of distance_antimagic_check_top.
`timescale 1ns / 1ps

module distance_antimagic_check_top_test;
  import dac_pkg::*;

  localparam int MAX_VERTICES = 8;
  localparam int LABEL_BITS   = 4;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    label_t lbl[NUM_LABELS];
    bit     wait_drain;
  } labeling_t;

  typedef struct {
    logic    is_antimagic;
    logic    has_twins;
    weight_t weight[NUM_LABELS];
  } vertex_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  label_t             label_0 = '0, label_1 = '0, label_2 = '0, label_3 = '0;
  label_t             label_4 = '0, label_5 = '0, label_6 = '0, label_7 = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               is_antimagic, has_twins;
  weight_t            weight_0, weight_1, weight_2, weight_3;
  weight_t            weight_4, weight_5, weight_6, weight_7;

  // graph as the block currently holds it
  logic [ADJ_W-1:0]   graph_adj = '0;
  logic [CNT_W-1:0]   graph_count = CNT_W'(8);

  labeling_t          labeling_q[$];
  vertex_result_t     expected_q[$];
  labeling_t          sent_labeling;
  int                 send_gap;
  bit                 send_burst;
  int                 stall_left;
  bit                 recv_burst;
  int                 err_cnt;
  int                 cycle_cnt;

  distance_antimagic_check_top #(
    .MAX_VERTICES(MAX_VERTICES),
    .LABEL_BITS  (LABEL_BITS)
  ) u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready,
    .label_0, .label_1, .label_2, .label_3, .label_4, .label_5, .label_6, .label_7,
    .out_valid, .out_ready, .is_antimagic, .has_twins,
    .weight_0, .weight_1, .weight_2, .weight_3,
    .weight_4, .weight_5, .weight_6, .weight_7
  );

  always #2 clk = ~clk;

  function automatic vertex_result_t predict_weights(input label_t lbl[NUM_LABELS],
                                                     input logic [ADJ_W-1:0] adj,
                                                     input logic [CNT_W-1:0] cnt);
    vertex_result_t r;
    int   n;
    int   sum[NUM_LABELS];
    row_t rows[NUM_LABELS];
    row_t in_use;
    n = (int'(cnt) > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
    in_use = row_t'((1 << n) - 1);
    r.is_antimagic = 1'b1;
    r.has_twins = 1'b0;
    for (int i = 0; i < NUM_LABELS; i++) begin
      rows[i] = adj[i*ROW_W +: ROW_W] & in_use;
      sum[i] = 0;
      if (i < n) begin
        for (int j = 0; j < n; j++) begin
          if (rows[i][j]) sum[i] += int'(lbl[j]) & ((1 << LABEL_BITS) - 1);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (sum[i] == sum[j]) r.is_antimagic = 1'b0;
        if (rows[i] == rows[j]) r.has_twins = 1'b1;
      end
    end
    for (int i = 0; i < NUM_LABELS; i++) begin
      r.weight[i] = (sum[i] > 127) ? weight_t'(127) : weight_t'(sum[i]);
    end
    return r;
  endfunction

  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic labeling_t random_labeling();
    labeling_t it;
    int        pool[16];
    int        mode, k, tmp;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 16; i++) pool[i] = i;
    for (int i = 15; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[k];
      pool[k] = tmp;
    end
    tmp = $urandom_range(0, 15);
    for (int i = 0; i < NUM_LABELS; i++) begin
      if (mode < 5) it.lbl[i] = label_t'(pool[i]);            // distinct labels
      else if (mode < 8) it.lbl[i] = label_t'($urandom_range(0, 15));
      else if (mode == 8) it.lbl[i] = $urandom_range(0, 1) ? '1 : '0;
      else it.lbl[i] = label_t'(tmp);
    end
    it.wait_drain = ($urandom_range(0, 149) == 0);
    return it;
  endfunction

  function automatic logic [ADJ_W-1:0] random_graph();
    logic [ADJ_W-1:0] adj;
    int               a, b;
    adj = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: adj = adj & {$urandom, $urandom};
      1: adj = adj | {$urandom, $urandom};
      default: ;
    endcase
    // mirror the upper triangle for an undirected graph
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < ROW_W; i++) begin
        for (int j = i + 1; j < ROW_W; j++) adj[j*ROW_W + i] = adj[i*ROW_W + j];
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      a = $urandom_range(0, 7);
      b = $urandom_range(0, 7);
      adj[b*ROW_W +: ROW_W] = adj[a*ROW_W +: ROW_W];
    end
    return adj;
  endfunction

  function automatic logic [CNT_W-1:0] random_count();
    if ($urandom_range(0, 4) == 0) return CNT_W'($urandom_range(0, 15));
    return CNT_W'($urandom_range(2, 8));
  endfunction

  task automatic push_word(input logic [31:0] w, input bit drain);
    labeling_t it;
    for (int i = 0; i < NUM_LABELS; i++) it.lbl[i] = w[i*LABEL_W +: LABEL_W];
    it.wait_drain = drain;
    labeling_q.insert(labeling_q.size(), it);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) labeling_q.insert(labeling_q.size(), random_labeling());
  endtask

  task automatic write_reg(input reg_sel_t sel, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_ADJ) graph_adj = data[ADJ_W-1:0];
    else graph_count = data[CNT_W-1:0];
  endtask

  task automatic set_graph(input logic [ADJ_W-1:0] adj, input logic [CNT_W-1:0] cnt);
    write_reg(REG_ADJ, PDATA_W'(adj));
    write_reg(REG_CNT, PDATA_W'(cnt));
  endtask

  task automatic wait_idle();
    while (labeling_q.size() != 0 || expected_q.size() != 0 || in_valid) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // request side
  always @(posedge clk) begin
    labeling_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_burst = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.insert(expected_q.size(),
                          predict_weights(sent_labeling.lbl, graph_adj, graph_count));
        if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
        send_gap = pick_gap(send_burst);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (labeling_q.size() != 0 &&
                     !(labeling_q[0].wait_drain && expected_q.size() != 0)) begin
          nxt = labeling_q.pop_front();
          sent_labeling = nxt;
          label_0 <= nxt.lbl[0];
          label_1 <= nxt.lbl[1];
          label_2 <= nxt.lbl[2];
          label_3 <= nxt.lbl[3];
          label_4 <= nxt.lbl[4];
          label_5 <= nxt.lbl[5];
          label_6 <= nxt.lbl[6];
          label_7 <= nxt.lbl[7];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    vertex_result_t exp_r;
    weight_t        got[NUM_LABELS];
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      recv_burst = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{weight_0, weight_1, weight_2, weight_3,
                weight_4, weight_5, weight_6, weight_7};
        if (expected_q.size() == 0) begin
          $error("result with no request pending");
          err_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (is_antimagic !== exp_r.is_antimagic) begin
            $error("is_antimagic: expected %0d, got %0d", exp_r.is_antimagic, is_antimagic);
            err_cnt++;
          end
          if (has_twins !== exp_r.has_twins) begin
            $error("has_twins: expected %0d, got %0d", exp_r.has_twins, has_twins);
            err_cnt++;
          end
          for (int i = 0; i < NUM_LABELS; i++) begin
            if (got[i] !== exp_r.weight[i]) begin
              $error("weight_%0d: expected %0d, got %0d", i, exp_r.weight[i], got[i]);
              err_cnt++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) == 0) recv_burst = ~recv_burst;
        stall_left = recv_burst ? 0 : pick_gap(1'b0);
        out_ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset graph: no edges, all eight vertices in use
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h7654_3210, 1'b0);
    push_random(20);
    wait_idle();

    // complete graph with loops: every weight is the full label sum
    set_graph('1, CNT_W'(8));
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hF0F0_F0F0, 1'b1);
    push_word(32'h8765_4321, 1'b0);
    push_random(40);
    wait_idle();

    // directed ring through all eight vertices
    set_graph(64'h0180_4020_1008_0402, CNT_W'(8));
    push_word(32'h8765_4321, 1'b0);
    push_word(32'hFEDC_BA98, 1'b0);
    push_random(40);
    wait_idle();

    set_graph(random_graph(), CNT_W'(0));
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h1234_5678, 1'b0);
    push_random(20);
    wait_idle();

    set_graph(64'h0000_0000_0000_00FF, CNT_W'(1));
    push_word(32'h0000_000F, 1'b0);
    push_word(32'hFFFF_FFF0, 1'b0);
    push_random(20);
    wait_idle();

    // counts above the vertex limit saturate
    set_graph(random_graph(), CNT_W'(15));
    push_word(32'hA5A5_A5A5, 1'b0);
    push_random(40);
    wait_idle();

    set_graph(random_graph(), CNT_W'(9));
    push_word(32'h5A5A_5A5A, 1'b0);
    push_random(40);
    wait_idle();

    set_graph(64'h8040_2010_0804_0201, CNT_W'(2));
    push_word(32'h0000_00FF, 1'b0);
    push_word(32'h0000_0033, 1'b0);
    push_random(20);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      set_graph(random_graph(), random_count());
      push_random(80);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/dac_pkg.sv
hdl/dac_lane.sv
hdl/dac_merge.sv
hdl/distance_antimagic_check_top.sv
tb/distance_antimagic_check_top_test.sv
